// ----- rtl/core/gwsc_pkg.sv -----
// Shared types, constants and helpers for the grid word search counter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package gwsc_pkg;

  localparam int CH_W       = 8;
  localparam int TOTAL_W    = 20;
  localparam int WORD_W     = 32;
  localparam int ROWW_W     = 9;
  localparam int COLW_W     = 24;  // one column of the line stores: {a, b, c}
  localparam int NUM_BANKS  = 8;
  localparam int BANK_SEL_W = 3;
  localparam int ADDR_W     = 3;
  localparam int REG_IDX_LSB = 2;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 20'hFFFFF;
  localparam logic [WORD_W-1:0]  WORD_RESET  = 32'h584D4153;  // "XMAS"
  localparam logic [ROWW_W-1:0]  WIDTH_RESET = 9'd140;
  localparam logic [1:0]         ROWS_FULL   = 2'd3;

  // register index, taken from paddr[REG_IDX_LSB]
  localparam logic REG_ROW_WIDTH   = 1'b0;
  localparam logic REG_SEARCH_WORD = 1'b1;

  typedef logic [COLW_W-1:0] col_word_t;

  typedef struct packed {
    logic last;
    logic full;      // three complete rows above
    logic col_ge3;   // room on the left
    logic right_ok;  // room on the right
    logic row_end;   // last column of the row
  } gwsc_flags_t;

  function automatic int col_bits(int max_cols);
    return ($clog2(max_cols) < BANK_SEL_W) ? BANK_SEL_W : $clog2(max_cols);
  endfunction

  function automatic int addr_bits(int max_cols);
    return (col_bits(max_cols) > BANK_SEL_W) ? col_bits(max_cols) - BANK_SEL_W : 1;
  endfunction

  // window slot (0 = col-3 ... 6 = col+3) that a bank holds for a given column
  function automatic logic [BANK_SEL_W-1:0] bank_slot(logic [BANK_SEL_W-1:0] bank,
                                                      logic [BANK_SEL_W-1:0] col_lo);
    return bank - col_lo + 3'd3;
  endfunction

  function automatic logic [WORD_W-1:0] reverse_word(logic [WORD_W-1:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

  function automatic logic [1:0] run_score(logic [WORD_W-1:0] run, logic [WORD_W-1:0] w);
    return {1'b0, run == w} + {1'b0, run == reverse_word(w)};
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gwsc_if.sv -----
// Valid/ready channel interfaces for the character input and the total output.
// Depends on gwsc_pkg for field widths.
`default_nettype none

interface gwsc_in_if import gwsc_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            last;

  modport source  (output valid, ch, last, input ready);
  modport sink    (input valid, ch, last, output ready);
  modport monitor (input valid, ready, ch, last);
endinterface

interface gwsc_out_if import gwsc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] match_total;

  modport source  (output valid, match_total, input ready);
  modport sink    (input valid, match_total, output ready);
  modport monitor (input valid, ready, match_total);
endinterface

`default_nettype wire

// ----- rtl/core/gwsc_cfg.sv -----
// APB-style register file: row width and search word.
// Depends on gwsc_pkg.
`default_nettype none

module gwsc_cfg import gwsc_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [WORD_W-1:0]   pwdata,
  output logic [WORD_W-1:0]   prdata,
  output logic                pready,
  output logic [ROWW_W-1:0]   row_width,
  output logic [WORD_W-1:0]   search_word
);

  logic wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width   <= WIDTH_RESET;
      search_word <= WORD_RESET;
    end else if (wr) begin
      unique case (paddr[REG_IDX_LSB])
        REG_ROW_WIDTH:   row_width   <= pwdata[ROWW_W-1:0];
        REG_SEARCH_WORD: search_word <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[REG_IDX_LSB])
      REG_ROW_WIDTH:   prdata = WORD_W'(row_width);
      REG_SEARCH_WORD: prdata = search_word;
      default:         prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/gwsc_bank.sv -----
// One bank of the line stores: a column word per entry, one write and one
// registered read per cycle, write-first on a same-address collision.
`default_nettype none

module gwsc_bank import gwsc_pkg::*; #(
  parameter int AW = 5
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  col_word_t     wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output col_word_t     rdata
);

  localparam int DEPTH = 1 << AW;

  col_word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= (we && (waddr == raddr)) ? wdata : mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/gwsc_track.sv -----
// Input stage: column/row tracking, character window, line-store read
// addresses and the working register. Depends on gwsc_pkg.
`default_nettype none

module gwsc_track import gwsc_pkg::*; #(
  parameter  int MAX_COLS = 256,
  localparam int CW = col_bits(MAX_COLS),
  localparam int AW = addr_bits(MAX_COLS)
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic [CH_W-1:0]                 in_ch,
  input  logic                            in_last,
  output logic                            in_ready,
  input  logic [ROWW_W-1:0]               row_width,
  input  logic                            s1_adv,
  output logic                            s1_valid,
  output logic [CH_W-1:0]                 s1_ch,
  output logic [CW-1:0]                   s1_col,
  output logic [3*CH_W-1:0]               s1_recent,
  output gwsc_flags_t                     s1_flags,
  output logic                            rd_en,
  output logic [NUM_BANKS-1:0][AW-1:0]    raddr
);

  logic [CW-1:0]     column_index;
  logic [1:0]        rows_seen;
  logic [3*CH_W-1:0] recent;
  logic [CW-1:0]     wlast;
  logic [CW-1:0]     col;
  logic              row_end;
  logic              accept;

  // last column index of a row, width clamped into 4..MAX_COLS
  always_comb begin
    if (row_width < ROWW_W'(4)) begin
      wlast = CW'(3);
    end else if (32'(row_width) > MAX_COLS) begin
      wlast = CW'(MAX_COLS - 1);
    end else begin
      wlast = CW'(row_width - ROWW_W'(1));
    end
  end

  assign col      = (column_index > wlast) ? wlast : column_index;
  assign row_end  = (col == wlast);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;
  assign rd_en    = accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      rows_seen    <= '0;
      recent       <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (accept) begin
        if (in_last) begin
          column_index <= '0;
          rows_seen    <= '0;
          recent       <= '0;
        end else begin
          column_index <= row_end ? '0 : col + CW'(1);
          if (row_end && (rows_seen != ROWS_FULL)) begin
            rows_seen <= rows_seen + 2'd1;
          end
          recent <= {recent[2*CH_W-1:0], in_ch};
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_ch             <= in_ch;
      s1_col            <= col;
      s1_recent         <= recent;
      s1_flags.last     <= in_last;
      s1_flags.full     <= (rows_seen == ROWS_FULL);
      s1_flags.col_ge3  <= (col >= CW'(3));
      s1_flags.right_ok <= ((CW+1)'(col) + (CW+1)'(3)) <= (CW+1)'(wlast);
      s1_flags.row_end  <= row_end;
    end
  end

  // columns col-3 .. col+3 fall in seven distinct banks
  always_comb begin
    logic [BANK_SEL_W-1:0] k;
    logic [CW-1:0]         colb;
    k    = '0;
    colb = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      k        = bank_slot(BANK_SEL_W'(b), col[BANK_SEL_W-1:0]);
      colb     = col - CW'(3) + CW'(k);
      raddr[b] = AW'(colb >> BANK_SEL_W);
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/gwsc_match.sv -----
// Working stage: run compares, saturating total, line-store commits and
// the result register. Depends on gwsc_pkg.
`default_nettype none

module gwsc_match import gwsc_pkg::*; #(
  parameter  int MAX_COLS = 256,
  localparam int CW = col_bits(MAX_COLS),
  localparam int AW = addr_bits(MAX_COLS)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s1_valid,
  input  logic [CH_W-1:0]                     s1_ch,
  input  logic [CW-1:0]                       s1_col,
  input  logic [3*CH_W-1:0]                   s1_recent,
  input  gwsc_flags_t                         s1_flags,
  input  logic [NUM_BANKS-1:0][COLW_W-1:0]    rdata,
  input  logic [WORD_W-1:0]                   search_word,
  output logic                                s1_adv,
  output logic [NUM_BANKS-1:0]                we,
  output logic [NUM_BANKS-1:0][AW-1:0]        waddr,
  output logic [NUM_BANKS-1:0][COLW_W-1:0]    wdata,
  output logic                                res_valid,
  output logic [TOTAL_W-1:0]                  res_total,
  input  logic                                out_ready
);

  localparam int WIN = 7;

  col_word_t          win [WIN];
  logic [WORD_W-1:0]  run_h, run_v, run_d, run_ad;
  logic [3:0]         hits;
  logic [TOTAL_W:0]   sum;
  logic [TOTAL_W-1:0] total_next;
  logic [TOTAL_W-1:0] hit_total;
  logic               fire;

  // word layout: [23:16] one row up, [15:8] two up, [7:0] three up
  always_comb begin
    logic [BANK_SEL_W-1:0] bi;
    bi = '0;
    for (int k = 0; k < WIN; k++) begin
      bi     = s1_col[BANK_SEL_W-1:0] + BANK_SEL_W'(k) - 3'd3;
      win[k] = rdata[bi];
    end
  end

  assign run_h  = {s1_recent, s1_ch};
  assign run_v  = {win[3][7:0], win[3][15:8], win[3][23:16], s1_ch};
  assign run_d  = {win[0][7:0], win[1][15:8], win[2][23:16], s1_ch};
  assign run_ad = {win[6][7:0], win[5][15:8], win[4][23:16], s1_ch};

  always_comb begin
    hits = '0;
    if (s1_flags.col_ge3) begin
      hits = hits + 4'(run_score(run_h, search_word));
    end
    if (s1_flags.full) begin
      hits = hits + 4'(run_score(run_v, search_word));
      if (s1_flags.col_ge3) begin
        hits = hits + 4'(run_score(run_d, search_word));
      end
      if (s1_flags.right_ok) begin
        hits = hits + 4'(run_score(run_ad, search_word));
      end
    end
  end

  assign sum        = {1'b0, hit_total} + (TOTAL_W+1)'(hits);
  assign total_next = sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];

  // a finished grid waits here while the previous total is still unread
  assign s1_adv = !(s1_flags.last && res_valid && !out_ready);
  assign fire   = s1_valid && s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_total <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && out_ready) begin
        res_valid <= 1'b0;
      end
      if (fire) begin
        hit_total <= s1_flags.last ? '0 : total_next;
        if (s1_flags.last) begin
          res_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && s1_flags.last) begin
      res_total <= total_next;
    end
  end

  // column col-3 shifts down on each step with col >= 3; col-2..col also at the row end
  always_comb begin
    logic [BANK_SEL_W-1:0] k;
    logic [CW-1:0]         colb;
    logic [CH_W-1:0]       newc;
    k    = '0;
    colb = '0;
    newc = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      k    = bank_slot(BANK_SEL_W'(b), s1_col[BANK_SEL_W-1:0]);
      colb = s1_col - CW'(3) + CW'(k);
      unique case (k)
        3'd0:    newc = s1_recent[3*CH_W-1:2*CH_W];
        3'd1:    newc = s1_recent[2*CH_W-1:CH_W];
        3'd2:    newc = s1_recent[CH_W-1:0];
        default: newc = s1_ch;
      endcase
      we[b]    = fire && (((k == 3'd0) && s1_flags.col_ge3) ||
                          (((k == 3'd1) || (k == 3'd2) || (k == 3'd3)) && s1_flags.row_end));
      waddr[b] = AW'(colb >> BANK_SEL_W);
      wdata[b] = {newc, rdata[b][23:16], rdata[b][15:8]};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/grid_word_search_counter_top.sv -----
// Grid word search counter: register file, tracking stage, eight line-store banks
// and the match stage. Depends on gwsc_pkg, gwsc_if and gwsc_cfg/track/bank/match.
//
// Usage:
//   item   : valid/ready channel of grid characters (ch) in row-major order,
//            last marks the final character of a grid.
//   result : valid/ready channel carrying match_total, one request per grid.
//   APB    : row_width at 0x0, search_word at 0x4; write between grids.
// One character is taken every cycle while ready is high. A character accepted
// at an edge has its line-store columns read at that same edge and enters the
// working stage, where it is scored and commits its column updates as it leaves;
// a grid total goes valid as the last character leaves. The line stores are eight
// banks of column words, one read and one write per bank per cycle; the seven
// columns around the current one always fall in different banks.
// The total sits in a result register, so characters keep flowing while it
// waits. Only if a second grid ends before the first total is taken does
// the last character stay in the working stage, and ready drops until the
// result is read. Reset clears the counters, window and total and restores
// row_width 140 and "XMAS"; line-store contents are don't-care until written.
`default_nettype none

module grid_word_search_counter_top import gwsc_pkg::*; #(
  parameter int MAX_COLS = 256
) (
  input  logic              clk,
  input  logic              rst,
  gwsc_in_if.sink           item,
  gwsc_out_if.source        result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [WORD_W-1:0] pwdata,
  output logic [WORD_W-1:0] prdata,
  output logic              pready
);

  localparam int CW = col_bits(MAX_COLS);
  localparam int AW = addr_bits(MAX_COLS);

  logic [ROWW_W-1:0]                row_width;
  logic [WORD_W-1:0]                search_word;
  logic                             s1_adv;
  logic                             s1_valid;
  logic [CH_W-1:0]                  s1_ch;
  logic [CW-1:0]                    s1_col;
  logic [3*CH_W-1:0]                s1_recent;
  gwsc_flags_t                      s1_flags;
  logic                             rd_en;
  logic [NUM_BANKS-1:0][AW-1:0]     raddr;
  logic [NUM_BANKS-1:0][COLW_W-1:0] rdata;
  logic [NUM_BANKS-1:0]             we;
  logic [NUM_BANKS-1:0][AW-1:0]     waddr;
  logic [NUM_BANKS-1:0][COLW_W-1:0] wdata;

  gwsc_cfg u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .row_width   (row_width),
    .search_word (search_word)
  );

  gwsc_track #(.MAX_COLS(MAX_COLS)) u_track (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (item.valid),
    .in_ch     (item.ch),
    .in_last   (item.last),
    .in_ready  (item.ready),
    .row_width (row_width),
    .s1_adv    (s1_adv),
    .s1_valid  (s1_valid),
    .s1_ch     (s1_ch),
    .s1_col    (s1_col),
    .s1_recent (s1_recent),
    .s1_flags  (s1_flags),
    .rd_en     (rd_en),
    .raddr     (raddr)
  );

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    gwsc_bank #(.AW(AW)) u_bank (
      .clk   (clk),
      .we    (we[b]),
      .waddr (waddr[b]),
      .wdata (wdata[b]),
      .re    (rd_en),
      .raddr (raddr[b]),
      .rdata (rdata[b])
    );
  end

  gwsc_match #(.MAX_COLS(MAX_COLS)) u_match (
    .clk         (clk),
    .rst         (rst),
    .s1_valid    (s1_valid),
    .s1_ch       (s1_ch),
    .s1_col      (s1_col),
    .s1_recent   (s1_recent),
    .s1_flags    (s1_flags),
    .rdata       (rdata),
    .search_word (search_word),
    .s1_adv      (s1_adv),
    .we          (we),
    .waddr       (waddr),
    .wdata       (wdata),
    .res_valid   (result.valid),
    .res_total   (result.match_total),
    .out_ready   (result.ready)
  );

endmodule

`default_nettype wire

// ----- rtl/core/gwsc_checker.sv -----
// Port-level checks for the grid word search counter, bound to the top level.
// Depends on gwsc_pkg and gwsc_if.
`default_nettype none

module gwsc_checker import gwsc_pkg::*; (
  input logic              clk,
  input logic              rst,
  gwsc_in_if.sink          item,
  gwsc_out_if.source       result,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [WORD_W-1:0] pwdata,
  input logic [WORD_W-1:0] prdata,
  input logic              pready
);

  // input only backs up when a total is waiting to be read
  a_ready_without_result: assert property (@(posedge clk)
    !result.valid |-> item.ready)
    else $error("input not ready while no result is pending");

  // grid total goes valid after a grid's last character is accepted
  a_total_latency: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && item.last) |-> ##2 result.valid)
    else $error("grid total missing after last character");

  // search word reads back what was written
  a_word_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && pready && (paddr[REG_IDX_LSB] == REG_SEARCH_WORD))
    ##1 (paddr[REG_IDX_LSB] == REG_SEARCH_WORD) |-> (prdata == $past(pwdata)))
    else $error("search word readback mismatch");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result.valid && !result.ready) |=> (result.valid && $stable(result.match_total)))
    else $error("stalled result request changed");

endmodule

bind grid_word_search_counter_top gwsc_checker u_gwsc_checker (
  .clk     (clk),
  .rst     (rst),
  .item    (item),
  .result  (result),
  .psel    (psel),
  .penable (penable),
  .pwrite  (pwrite),
  .paddr   (paddr),
  .pwdata  (pwdata),
  .prdata  (prdata),
  .pready  (pready)
);

`default_nettype wire
